@@ rtl/core/message_header_varint_parser_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the message header varint parser
// Shared helpers that clock on clk and switch off during reset.
// ----------------------------------------------------------------------------
`ifndef MESSAGE_HEADER_VARINT_PARSER_ASSERT_SVH
`define MESSAGE_HEADER_VARINT_PARSER_ASSERT_SVH

// Same-cycle implication.
`define MHVP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MHVP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/mhvp_pkg.sv @@
// ----------------------------------------------------------------------------
// mhvp_pkg
// Types and codes shared by the message header varint parser modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mhvp_pkg;

  localparam int MAX_VARINT_BYTES_DEF = 4;
  localparam int CNT_W = 3;
  localparam int VAL_W = 28;

  localparam logic [7:0] FRAG_MASK_RST = 8'h80;
  localparam logic [7:0] CONT_BIT = 8'h80;

  localparam logic [2:0] PH_TYPE  = 3'd0;
  localparam logic [2:0] PH_FLAGS = 3'd1;
  localparam logic [2:0] PH_SEQ   = 3'd2;
  localparam logic [2:0] PH_LEN   = 3'd3;
  localparam logic [2:0] PH_OFS   = 3'd4;
  localparam logic [2:0] PH_DONE  = 3'd5;
  localparam logic [2:0] PH_BAD   = 3'd6;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_TRUNC = 2'd1;
  localparam logic [1:0] ST_MALF  = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [7:0]       msg_type;
    logic [7:0]       flag_bits;
    logic [7:0]       sequence_number;
    logic [VAL_W-1:0] body_length;
    logic [CNT_W-1:0] length_width;
    logic [VAL_W-1:0] fragment_offset;
    logic [CNT_W-1:0] offset_width;
    logic [3:0]       header_bytes;
  } out_item_t;

endpackage

@@ rtl/core/mhvp_parse_core.sv @@
// ----------------------------------------------------------------------------
// mhvp_parse_core
// Per-byte header parser state and the result formed on the last byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mhvp_parse_core
  import mhvp_pkg::*;
#(
  parameter int MAX_VARINT_BYTES = MAX_VARINT_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      accept,
  input  in_item_t  item,
  input  logic [7:0] frag_mask,
  output logic      res_valid,
  output out_item_t res_item
);

  logic [2:0]       phase_r, phase_nxt;
  logic [7:0]       type_r, type_nxt;
  logic [7:0]       flags_r, flags_nxt;
  logic [7:0]       seq_r, seq_nxt;
  logic [VAL_W-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [VAL_W-1:0] len_r, len_nxt;
  logic [CNT_W-1:0] lcnt_r, lcnt_nxt;

  logic [5:0]       shift_amt;
  logic [VAL_W-1:0] acc_add;
  logic [CNT_W-1:0] cnt_inc;
  logic [7:0]       b;
  logic             is_ok;

  assign b         = item.data_byte;
  assign shift_amt = 6'(cnt_r) * 6'd7;
  assign acc_add   = acc_r | (VAL_W'(b[6:0]) << shift_amt);
  assign cnt_inc   = cnt_r + CNT_W'(1);

  always_comb begin
    phase_nxt = phase_r;
    type_nxt  = type_r;
    flags_nxt = flags_r;
    seq_nxt   = seq_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    len_nxt   = len_r;
    lcnt_nxt  = lcnt_r;
    if (accept) begin
      case (phase_r)
        PH_TYPE: begin
          type_nxt  = b;
          phase_nxt = PH_FLAGS;
        end
        PH_FLAGS: begin
          flags_nxt = b;
          phase_nxt = PH_SEQ;
        end
        PH_SEQ: begin
          seq_nxt   = b;
          acc_nxt   = '0;
          cnt_nxt   = '0;
          phase_nxt = PH_LEN;
        end
        PH_LEN, PH_OFS: begin
          acc_nxt = acc_add;
          cnt_nxt = cnt_inc;
          if ((b & CONT_BIT) == 8'h00) begin
            if (phase_r == PH_LEN) begin
              len_nxt   = acc_add;
              lcnt_nxt  = cnt_inc;
              acc_nxt   = '0;
              cnt_nxt   = '0;
              phase_nxt = ((flags_r & frag_mask) != 8'h00) ? PH_OFS : PH_DONE;
            end else begin
              phase_nxt = PH_DONE;
            end
          end else if ((cnt_inc >= CNT_W'(MAX_VARINT_BYTES)) && !item.last_byte) begin
            phase_nxt = PH_BAD;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // The result reflects the state after this byte is folded in.
  assign res_valid = accept && item.last_byte;
  assign is_ok     = (phase_nxt == PH_DONE);

  always_comb begin
    if (is_ok) begin
      res_item.status = ST_OK;
    end else if (phase_nxt == PH_BAD) begin
      res_item.status = ST_MALF;
    end else begin
      res_item.status = ST_TRUNC;
    end
    res_item.msg_type        = type_nxt;
    res_item.flag_bits       = flags_nxt;
    res_item.sequence_number = seq_nxt;
    res_item.body_length     = len_nxt;
    res_item.length_width    = lcnt_nxt;
    res_item.fragment_offset = is_ok ? acc_nxt : '0;
    res_item.offset_width    = is_ok ? cnt_nxt : '0;
    res_item.header_bytes    = is_ok ? (4'd3 + 4'(lcnt_nxt) + 4'(cnt_nxt)) : 4'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || res_valid) begin
      phase_r <= PH_TYPE;
      type_r  <= '0;
      flags_r <= '0;
      seq_r   <= '0;
      acc_r   <= '0;
      cnt_r   <= '0;
      len_r   <= '0;
      lcnt_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      type_r  <= type_nxt;
      flags_r <= flags_nxt;
      seq_r   <= seq_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      len_r   <= len_nxt;
      lcnt_r  <= lcnt_nxt;
    end
  end

endmodule

@@ rtl/core/mhvp_out_reg.sv @@
// ----------------------------------------------------------------------------
// mhvp_out_reg
// Result register holding one item until the downstream side takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mhvp_out_reg
  import mhvp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  out_item_t load_item,
  input  logic      out_stall,
  output logic      out_valid,
  output out_item_t out_item
);

  logic      valid_r, valid_nxt;
  out_item_t item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= load_item;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

@@ rtl/core/message_header_varint_parser.sv @@
// ----------------------------------------------------------------------------
// message_header_varint_parser
// Byte-stream message header parser with base-128 length and offset fields.
// ----------------------------------------------------------------------------
// The block takes one byte item per clock cycle unless it stalls the input
// and returns one result item for each buffer in the cycle after the byte
// marked as the buffer's last is taken. Bytes 0 to 2 are type, flags and
// sequence; a little-endian varint length follows, and an offset varint
// follows it when the flags byte hits the fragment mask. For each byte the
// parser state is updated by a single shift-or and phase step, and the
// result lands in an output register. The input is stalled only while that
// register holds a result the downstream side has not yet taken, so the
// sustained rate is one byte per cycle when the output keeps up. The
// fragment mask is written through the cfg port, which is always ready, and
// is sampled when the length varint completes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "message_header_varint_parser_assert.svh"

module message_header_varint_parser
  import mhvp_pkg::*;
#(
  parameter int MAX_VARINT_BYTES = MAX_VARINT_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_item,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_item,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  logic [7:0] frag_mask_r;
  logic       in_accept;
  logic       res_valid;
  out_item_t  res_item;

  // Short names for the terms that the checks at the end use.
  logic       in_last_accept;
  logic       out_ok;
  logic       out_zero_tail;
  logic [3:0] hdr_sum;

  // Configuration writes land at once, so the port never pushes back.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frag_mask_r <= FRAG_MASK_RST;
    end else if (cfg_valid && cfg_ready) begin
      frag_mask_r <= cfg_data;
    end
  end

  // Any byte might end a buffer, so hold input only when the result
  // register is full and blocked.
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  mhvp_parse_core #(
    .MAX_VARINT_BYTES(MAX_VARINT_BYTES)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_accept),
    .item     (in_item),
    .frag_mask(frag_mask_r),
    .res_valid(res_valid),
    .res_item (res_item)
  );

  mhvp_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (res_valid),
    .load_item(res_item),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  assign in_last_accept = in_accept && in_item.last_byte;
  assign out_ok         = out_valid && (out_item.status == ST_OK);
  assign out_zero_tail  = (out_item.header_bytes == 4'd0) && (out_item.offset_width == '0);
  assign hdr_sum        = 4'd3 + 4'(out_item.length_width) + 4'(out_item.offset_width);

  `MHVP_ASSERT_NOW(a_no_overwrite, out_valid && out_stall, !in_accept, "result overwritten")
  `MHVP_ASSERT_NEXT(a_last_gives_result, in_last_accept, out_valid, "last byte gave no result")
  `MHVP_ASSERT_NOW(a_ok_hdr_len, out_ok, out_item.header_bytes == hdr_sum, "bad header length")
  `MHVP_ASSERT_NOW(a_bad_zero, out_valid && !out_ok, out_zero_tail, "failed parse has header")

endmodule

@@ tb/sv/mhvp_header_checker.sv @@
// ----------------------------------------------------------------------------
// mhvp_header_checker
// Watches the byte, result and mask channels of the header parser, decodes
// each accepted byte on its own copy of the parse state and compares every
// result item field by field with the oldest decoded header.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mhvp_header_checker
  import mhvp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  in_item_t   in_item,
  input  logic       out_valid,
  input  logic       out_stall,
  input  out_item_t  out_item,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [7:0] cfg_data,
  output int         fail_count,
  output int         pending,
  output int         ok_count,
  output int         trunc_count,
  output int         malf_count
);

  localparam int MaxVarintBytes = MAX_VARINT_BYTES_DEF;

  logic [7:0]       frag_mask;
  logic [2:0]       phase;
  logic [7:0]       type_q;
  logic [7:0]       flags_q;
  logic [7:0]       seq_q;
  logic [VAL_W-1:0] acc_q;
  logic [CNT_W-1:0] acc_cnt;
  logic [VAL_W-1:0] length_q;
  logic [CNT_W-1:0] length_cnt;
  out_item_t        expected_headers[$];
  out_item_t        want;
  string            diff;
  int               result_idx;

  function automatic string show(input out_item_t r);
    return $sformatf("status=%0d type=%02h flags=%02h seq=%02h len=%07h/%0d ofs=%07h/%0d hdr=%0d",
                     r.status, r.msg_type, r.flag_bits, r.sequence_number,
                     r.body_length, r.length_width, r.fragment_offset,
                     r.offset_width, r.header_bytes);
  endfunction

  task automatic clear_parse();
    phase      = PH_TYPE;
    type_q     = '0;
    flags_q    = '0;
    seq_q      = '0;
    acc_q      = '0;
    acc_cnt    = '0;
    length_q   = '0;
    length_cnt = '0;
  endtask

  // Advances the parse by one byte and, on the buffer's last byte, queues the
  // header that the block must report.
  task automatic decode_header_byte(input in_item_t it);
    out_item_t  res;
    logic [7:0] b;
    b = it.data_byte;
    case (phase)
      PH_TYPE: begin
        type_q = b;
        phase  = PH_FLAGS;
      end
      PH_FLAGS: begin
        flags_q = b;
        phase   = PH_SEQ;
      end
      PH_SEQ: begin
        seq_q   = b;
        acc_q   = '0;
        acc_cnt = '0;
        phase   = PH_LEN;
      end
      PH_LEN, PH_OFS: begin
        if (7 * acc_cnt < VAL_W) begin
          acc_q = acc_q | (VAL_W'(b[6:0]) << (7 * acc_cnt));
        end
        acc_cnt = acc_cnt + 1'b1;
        if ((b & CONT_BIT) == 8'h00) begin
          if (phase == PH_LEN) begin
            length_q   = acc_q;
            length_cnt = acc_cnt;
            acc_q      = '0;
            acc_cnt    = '0;
            phase      = ((flags_q & frag_mask) != 8'h00) ? PH_OFS : PH_DONE;
          end else begin
            phase = PH_DONE;
          end
        end else if (acc_cnt >= MaxVarintBytes && !it.last_byte) begin
          phase = PH_BAD;
        end
      end
      default: begin
      end
    endcase

    if (it.last_byte) begin
      res                 = '0;
      res.msg_type        = type_q;
      res.flag_bits       = flags_q;
      res.sequence_number = seq_q;
      res.body_length     = length_q;
      res.length_width    = length_cnt;
      if (phase == PH_DONE) begin
        res.status          = ST_OK;
        res.fragment_offset = acc_q;
        res.offset_width    = acc_cnt;
        res.header_bytes    = 4'(3 + length_cnt + acc_cnt);
      end else if (phase == PH_BAD) begin
        res.status = ST_MALF;
      end else begin
        res.status = ST_TRUNC;
      end
      expected_headers.push_back(res);
      clear_parse();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      frag_mask = FRAG_MASK_RST;
      clear_parse();
      expected_headers.delete();
      fail_count  = 0;
      pending     = 0;
      ok_count    = 0;
      trunc_count = 0;
      malf_count  = 0;
      result_idx  = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        frag_mask = cfg_data;
      end
      if (in_valid && !in_stall) begin
        decode_header_byte(in_item);
      end
      if (out_valid && !out_stall) begin
        if (expected_headers.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("ERROR: result %0d came with no header pending: %s",
                     result_idx, show(out_item));
          end
        end else begin
          want = expected_headers.pop_front();
          diff = "";
          if (out_item.status !== want.status) diff = {diff, " status"};
          if (out_item.msg_type !== want.msg_type) diff = {diff, " msg_type"};
          if (out_item.flag_bits !== want.flag_bits) diff = {diff, " flag_bits"};
          if (out_item.sequence_number !== want.sequence_number) diff = {diff, " sequence_number"};
          if (out_item.body_length !== want.body_length) diff = {diff, " body_length"};
          if (out_item.length_width !== want.length_width) diff = {diff, " length_width"};
          if (out_item.fragment_offset !== want.fragment_offset) diff = {diff, " fragment_offset"};
          if (out_item.offset_width !== want.offset_width) diff = {diff, " offset_width"};
          if (out_item.header_bytes !== want.header_bytes) diff = {diff, " header_bytes"};
          if (diff != "") begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("ERROR: result %0d differs in%s", result_idx, diff);
              $display("  expected %s", show(want));
              $display("  actual   %s", show(out_item));
            end
          end
          case (want.status)
            ST_OK:    ok_count++;
            ST_TRUNC: trunc_count++;
            default:  malf_count++;
          endcase
        end
        result_idx++;
      end
      pending = expected_headers.size();
    end
  end

endmodule

@@ tb/sv/tb_message_header_varint_parser.sv @@
// ----------------------------------------------------------------------------
// tb_message_header_varint_parser
// Drives message buffers byte by byte into the header parser under random
// sender gaps and receiver stalls, across several fragment mask settings.
// The checker beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_message_header_varint_parser;
  import mhvp_pkg::*;

  // Bytes of random stimulus in total, spread evenly over the mask phases.
  localparam int RandomBytes = 1700;
  localparam int MaskPhases  = 5;
  // Worst case is roughly 1700 bytes, each with a sender gap and a heavily
  // stalled result behind it; this limit sits far above that.
  localparam int CycleLimit  = 400000;

  // Receiver behavior, picked anew at random by the stall process below.
  typedef enum int {RX_FREE, RX_PATCHY, RX_CHOKED} rx_mode_t;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  in_item_t   in_item   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_item;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data  = '0;

  int fail_count;
  int pending;
  int ok_count;
  int trunc_count;
  int malf_count;

  int         bytes_sent;
  int         buffers_sent;
  int         mask_settings;
  int         cycle_count;
  int         burst_left;
  int         stall_left;
  rx_mode_t   rx_mode = RX_FREE;
  bit         steady;
  logic [7:0] current_mask;
  logic [7:0] frame_q[$];

  message_header_varint_parser DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  mhvp_header_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .pending     (pending),
    .ok_count    (ok_count),
    .trunc_count (trunc_count),
    .malf_count  (malf_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // A hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results still outstanding",
               cycle_count, pending);
      $display("tb_message_header_varint_parser failed");
      $finish;
    end
  end

  // The receiver stalls on a pattern of its own: it stays in one mode for a
  // random stretch, from never stalling to stalling most of the time.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      rx_mode    = rx_mode_t'($urandom_range(0, 2));
      stall_left = $urandom_range(20, 120);
    end else begin
      stall_left--;
    end
    case (rx_mode)
      RX_FREE:   out_stall <= 1'b0;
      RX_PATCHY: out_stall <= ($urandom_range(0, 99) < 40);
      default:   out_stall <= ($urandom_range(0, 99) < 85);
    endcase
  end

  // Presents one byte item and holds it until the block takes it. The sender
  // works in bursts; between bursts valid drops for a random gap, unless the
  // current phase runs steady. Called and returns at a falling edge.
  task automatic send_byte(input logic [7:0] value, input logic is_last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item  <= {value, is_last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  // Sends the assembled buffer, marking its final byte as the last one.
  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++) begin
      send_byte(frame_q[i], i == frame_q.size() - 1);
    end
    buffers_sent++;
  endtask

  // Holds the input idle until every pending header has been reported and
  // nothing is still in flight.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    burst_left = 0;
  endtask

  // Writes the fragment mask. Only called while the block is idle.
  task automatic write_mask(input logic [7:0] mask);
    cfg_valid <= 1'b1;
    cfg_data  <= mask;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    current_mask = mask;
    mask_settings++;
  endtask

  // Appends a varint of the given byte count with random value groups. An
  // overlong one carries the continuation bit on all of its maximum bytes.
  task automatic push_varint(input int width, input bit overlong);
    int nbytes;
    nbytes = overlong ? MAX_VARINT_BYTES_DEF : width;
    for (int i = 0; i < nbytes; i++) begin
      frame_q.push_back({overlong || (i != nbytes - 1), 7'($urandom)});
    end
  endtask

  // Builds one random buffer. Most are well formed with random content and
  // trailing bytes; the rest are cut short, carry an overlong length or
  // offset varint, or are plain noise.
  task automatic send_random_frame();
    int         kind;
    int         cut;
    logic [7:0] flags;
    bit         frag;
    bit         bad_len;
    bit         bad_ofs;
    frame_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 12)) frame_q.push_back(8'($urandom));
    end else begin
      // Bias the flags toward hitting or missing the mask on purpose, but
      // leave a third of them fully random.
      flags = 8'($urandom);
      if ($urandom_range(0, 2) != 0) begin
        flags = $urandom_range(0, 1) ? (flags | current_mask) : (flags & ~current_mask);
      end
      frag    = (flags & current_mask) != 8'h00;
      bad_len = (kind >= 80 && kind < 88);
      bad_ofs = (kind >= 88);
      frame_q.push_back(8'($urandom));
      frame_q.push_back(flags);
      frame_q.push_back(8'($urandom));
      push_varint($urandom_range(1, MAX_VARINT_BYTES_DEF), bad_len);
      if (frag && !bad_len) begin
        push_varint($urandom_range(1, MAX_VARINT_BYTES_DEF), bad_ofs);
      end
      // Trailing bytes; with none, an overlong varint ends on its fourth
      // byte and has to come back as truncated rather than malformed.
      repeat ($urandom_range(0, 3)) frame_q.push_back(8'($urandom));
      if (kind >= 60 && kind < 80) begin
        cut = $urandom_range(1, frame_q.size());
        while (frame_q.size() > cut) void'(frame_q.pop_back());
      end
    end
    send_frame();
  endtask

  initial begin
    logic [7:0] mask_plan[MaskPhases];
    int         phase_start;

    mask_plan[0] = 8'h00;
    mask_plan[1] = 8'hFF;
    mask_plan[2] = 8'h01;
    mask_plan[3] = 8'($urandom);
    mask_plan[4] = FRAG_MASK_RST;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed buffers under the reset mask value.
    write_mask(FRAG_MASK_RST);
    steady = 1'b0;

    // A buffer of a single byte.
    frame_q = '{8'hFF};
    send_frame();
    // Header bytes only, ending before the length varint.
    frame_q = '{8'h00, 8'h80, 8'h00};
    send_frame();
    // Fragmented message with the largest four-byte length and a zero offset.
    frame_q = '{8'hFF, 8'h80, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h00};
    send_frame();
    // Length varint still continuing at its fourth byte, then a trailing byte.
    frame_q = '{8'h01, 8'h7F, 8'h02, 8'h80, 8'h80, 8'h80, 8'h80, 8'h55};
    send_frame();
    // The same overlong varint, but the buffer ends on its fourth byte.
    frame_q = '{8'h00, 8'h00, 8'h00, 8'h81, 8'h82, 8'h83, 8'h84};
    send_frame();
    settle();

    // Random phases, one per mask setting. Each phase starts from an idle
    // block, and one of them runs the sender without any gaps.
    for (int p = 0; p < MaskPhases; p++) begin
      write_mask(mask_plan[p]);
      steady      = (p == 2);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < RandomBytes / MaskPhases) begin
        send_random_frame();
        // Now and then the sender waits for every result to come back.
        if ($urandom_range(0, 49) == 0) begin
          settle();
        end
      end
      settle();
    end

    repeat (10) @(negedge clk);
    $display("Sent %0d bytes in %0d buffers under %0d fragment mask settings.",
             bytes_sent, buffers_sent, mask_settings);
    $display("Headers checked: %0d ok, %0d truncated, %0d malformed; %0d mismatches.",
             ok_count, trunc_count, malf_count, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_message_header_varint_parser passed");
    end else begin
      $display("tb_message_header_varint_parser failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/mhvp_pkg.sv
rtl/core/mhvp_parse_core.sv
rtl/core/mhvp_out_reg.sv
rtl/core/message_header_varint_parser.sv
tb/sv/mhvp_header_checker.sv
tb/sv/tb_message_header_varint_parser.sv
